@@ rtl/core/mpxt_pkg.sv @@
// Shared types, constants and state codes for the maximum pair XOR trie block.
`default_nettype none

package mpxt_pkg;

   localparam int VALUE_W          = 32;
   localparam int COUNT_W          = 11;
   localparam int KEY_BITS_DEF     = 32;
   localparam int MAX_ITEMS_DEF    = 1024;
   localparam int NODE_SLOTS_DEF   = 32768;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               last;
   } req_type;

   typedef struct packed {
      logic [VALUE_W-1:0] max_xor;
      logic [COUNT_W-1:0] item_count;
      logic               overflow;
      logic               set_done;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_WALK,
      ST_BUILD,
      ST_QUERY,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

@@ rtl/core/max_pair_xor_trie.sv @@
// Running maximum XOR of any two numbers in a set, using a binary trie in a node memory.
// Each new key is inserted by a walk down the trie that builds any missing nodes, then
//   queried by a walk with one node memory read per trie level; a duplicate builds none.
// A new request is taken only when idle; one that finds the set or node memory full is
//   dropped. A finished response waits in an output register while the next is taken.
// Reset: one cycle after reset clears the root node, then requests are accepted.
`default_nettype none

module max_pair_xor_trie
   import mpxt_pkg::*;
#(
   parameter int KEY_BITS   = KEY_BITS_DEF,
   parameter int MAX_ITEMS  = MAX_ITEMS_DEF,
   parameter int NODE_SLOTS = NODE_SLOTS_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   localparam int IDX_W = $clog2(NODE_SLOTS);
   localparam int NU_W  = $clog2(NODE_SLOTS + 1);
   localparam int IT_W  = $clog2(MAX_ITEMS + 1);
   localparam int LVL_W = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;

   typedef logic [1:0][IDX_W-1:0] node_type;

   node_type node_mem [NODE_SLOTS];

   state_type             state_ff, state_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [KEY_BITS-1:0]   key_sr_ff, key_sr_in;
   logic [KEY_BITS-1:0]   acc_ff, acc_in;
   logic                  last_ff, last_in;
   logic [LVL_W-1:0]      lvl_ff, lvl_in;
   logic [IDX_W-1:0]      cur_ff, cur_in;
   logic [NU_W-1:0]       nodes_used_ff, nodes_used_in;
   logic [VALUE_W-1:0]    max_ff, max_in;
   logic [IT_W-1:0]       items_ff, items_in;
   logic                  ovf_ff, ovf_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;
   node_type              rd_data_ff;

   logic                  mem_we;
   logic [IDX_W-1:0]      mem_wa;
   node_type              mem_wd;
   logic [IDX_W-1:0]      rd_addr;

   logic                  bit_now;
   logic [IDX_W-1:0]      child;
   logic [IDX_W-1:0]      opp;
   logic                  acc_bit;
   logic [KEY_BITS-1:0]   acc_next;
   logic [NU_W-1:0]       need;
   logic [NU_W-1:0]       free_nodes;

   assign bit_now    = key_sr_ff[KEY_BITS-1];
   assign child      = rd_data_ff[bit_now];
   assign opp        = rd_data_ff[!bit_now];
   assign acc_bit    = (opp != '0);
   assign acc_next   = (acc_ff << 1) | KEY_BITS'(acc_bit);
   assign need       = NU_W'(lvl_ff) + NU_W'(1);
   assign free_nodes = NU_W'(NODE_SLOTS) - nodes_used_ff;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in      = state_ff;
      key_in        = key_ff;
      key_sr_in     = key_sr_ff;
      acc_in        = acc_ff;
      last_in       = last_ff;
      lvl_in        = lvl_ff;
      cur_in        = cur_ff;
      nodes_used_in = nodes_used_ff;
      max_in        = max_ff;
      items_in      = items_ff;
      ovf_in        = ovf_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      mem_we        = 1'b0;
      mem_wa        = cur_ff;
      mem_wd        = rd_data_ff;
      rd_addr       = '0;

      case (state_ff)
         ST_INIT: begin
            mem_we   = 1'b1;
            mem_wa   = '0;
            mem_wd   = '0;
            state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               key_in    = KEY_BITS'(req_data.value);
               key_sr_in = KEY_BITS'(req_data.value);
               last_in   = req_data.last;
               lvl_in    = LVL_W'(KEY_BITS - 1);
               cur_in    = '0;
               if (items_ff >= IT_W'(MAX_ITEMS)) begin
                  ovf_in   = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            if (child != '0) begin
               cur_in    = child;
               rd_addr   = child;
               key_sr_in = key_sr_ff << 1;
               lvl_in    = lvl_ff - LVL_W'(1);
               if (lvl_ff == '0) begin
                  // duplicate: whole path exists
                  rd_addr   = '0;
                  key_sr_in = key_ff;
                  lvl_in    = LVL_W'(KEY_BITS - 1);
                  acc_in    = '0;
                  items_in  = items_ff + IT_W'(1);
                  state_in  = ST_QUERY;
               end
            end else if (need <= free_nodes) begin
               mem_we          = 1'b1;
               mem_wa          = cur_ff;
               mem_wd          = rd_data_ff;
               mem_wd[bit_now] = IDX_W'(nodes_used_ff);
               key_sr_in       = key_sr_ff << 1;
               state_in        = ST_BUILD;
            end else begin
               ovf_in   = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_BUILD: begin
            mem_we        = 1'b1;
            mem_wa        = IDX_W'(nodes_used_ff);
            mem_wd        = '0;
            nodes_used_in = nodes_used_ff + NU_W'(1);
            if (lvl_ff == '0) begin
               rd_addr   = '0;
               key_sr_in = key_ff;
               lvl_in    = LVL_W'(KEY_BITS - 1);
               acc_in    = '0;
               items_in  = items_ff + IT_W'(1);
               state_in  = ST_QUERY;
            end else begin
               mem_wd[bit_now] = IDX_W'(nodes_used_ff + NU_W'(1));
               key_sr_in       = key_sr_ff << 1;
               lvl_in          = lvl_ff - LVL_W'(1);
            end
         end
         ST_QUERY: begin
            rd_addr   = acc_bit ? opp : child;
            acc_in    = acc_next;
            key_sr_in = key_sr_ff << 1;
            lvl_in    = lvl_ff - LVL_W'(1);
            if (lvl_ff == '0) begin
               if (VALUE_W'(acc_next) > max_ff) begin
                  max_in = VALUE_W'(acc_next);
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.max_xor    = max_ff;
               rsp_data_in.item_count = COUNT_W'(items_ff);
               rsp_data_in.overflow   = ovf_ff;
               rsp_data_in.set_done   = last_ff;
               if (last_ff) begin
                  mem_we        = 1'b1;
                  mem_wa        = '0;
                  mem_wd        = '0;
                  nodes_used_in = NU_W'(1);
                  max_in        = '0;
                  items_in      = '0;
                  ovf_in        = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         nodes_used_ff <= NU_W'(1);
         max_ff        <= '0;
         items_ff      <= '0;
         ovf_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         nodes_used_ff <= nodes_used_in;
         max_ff        <= max_in;
         items_ff      <= items_in;
         ovf_ff        <= ovf_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      key_sr_ff   <= key_sr_in;
      acc_ff      <= acc_in;
      last_ff     <= last_in;
      lvl_ff      <= lvl_in;
      cur_ff      <= cur_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         node_mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= node_mem[rd_addr];
   end

endmodule

`default_nettype wire
